// ----- sv/sacl_pkg.sv -----
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package sacl_pkg;

	localparam int MAX_SET_BITS = 6;
	localparam int MAX_WAYS     = 4;
	localparam int NUM_SETS     = 1 << MAX_SET_BITS;
	localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int REC_W        = WAY_W;
	localparam int WCNT_W       = $clog2(MAX_WAYS + 1);
	localparam int TAG_W        = 64;
	localparam int ADDR_W       = 64;
	localparam int CNT_W        = 32;
	localparam int PADDR_W      = 4;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [REC_W-1:0] REC_MAX   = REC_W'(MAX_WAYS - 1);

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_STORE  = 2'd1;
	localparam logic [1:0] CMD_MODIFY = 2'd2;

	localparam logic [1:0] REG_SET_BITS    = 2'd0;
	localparam logic [1:0] REG_BLOCK_BITS  = 2'd1;
	localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

	typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_t;
	typedef logic [MAX_WAYS-1:0][REC_W-1:0] rec_row_t;

	typedef struct packed {
		logic [2:0] set_bits;
		logic [5:0] block_bits;
		logic [2:0] ways_in_use;
	} cfg_t;

	typedef struct packed {
		logic rd_en;
		logic lookup_en;
	} ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} state_t;

	function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] v, logic [1:0] inc);
		logic [CNT_W:0] s;
		s = {1'b0, v} + {{(CNT_W-1){1'b0}}, inc};
		return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage

// ----- sv/sacl_regs.sv -----
// ----------------------------------------------------------------------------
// sacl_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module sacl_regs
	import sacl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_bits    <= 3'd0;
			cfg_q.block_bits  <= 6'd0;
			cfg_q.ways_in_use <= 3'd1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SET_BITS:    cfg_q.set_bits    <= pwdata[2:0];
				REG_BLOCK_BITS:  cfg_q.block_bits  <= pwdata[5:0];
				REG_WAYS_IN_USE: cfg_q.ways_in_use <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SET_BITS:    prdata = {29'd0, cfg_q.set_bits};
			REG_BLOCK_BITS:  prdata = {26'd0, cfg_q.block_bits};
			REG_WAYS_IN_USE: prdata = {29'd0, cfg_q.ways_in_use};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

// ----- sv/sacl_ctrl.sv -----
// ----------------------------------------------------------------------------
// sacl_ctrl
// Access sequencer: row read on accept, then a lookup state that writes the row back.
// ----------------------------------------------------------------------------
module sacl_ctrl
	import sacl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output ctl_t ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ctl.rd_en     = 1'b0;
		ctl.lookup_en = 1'b0;
		busy          = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.rd_en = 1'b1;
					state_d   = ST_LOOK;
				end
			end
			ST_LOOK: begin
				busy          = 1'b1;
				ctl.lookup_en = 1'b1;
				state_d       = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- sv/sacl_dpath.sv -----
// ----------------------------------------------------------------------------
// sacl_dpath
// Address split, tag and recency memories, valid bits, hit and victim logic,
// saturating totals and result registers.
// ----------------------------------------------------------------------------
module sacl_dpath
	import sacl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	input  cfg_t              cfg,
	input  logic [1:0]        command,
	input  logic [ADDR_W-1:0] address,
	output logic              done,
	output logic              was_hit,
	output logic              was_evicted,
	output logic              second_hit,
	output logic [CNT_W-1:0]  hits_total,
	output logic [CNT_W-1:0]  misses_total,
	output logic [CNT_W-1:0]  evictions_total
);

	tag_row_t tag_mem [NUM_SETS];
	rec_row_t rec_mem [NUM_SETS];

	logic [NUM_SETS-1:0][MAX_WAYS-1:0] valid_q;

	tag_row_t          rd_tags_s1;
	rec_row_t          rd_rec_s1;
	logic [1:0]        cmd_q;
	logic [TAG_W-1:0]  tag_q;
	logic [SET_W-1:0]  set_q;

	logic [CNT_W-1:0]  hits_q;
	logic [CNT_W-1:0]  misses_q;
	logic [CNT_W-1:0]  evict_q;
	logic              done_q;
	logic              was_hit_q;
	logic              was_evicted_q;
	logic              second_hit_q;

	// address split
	logic [2:0]        sb;
	logic [6:0]        split;
	logic [ADDR_W-1:0] set_full;
	logic [ADDR_W-1:0] set_mask;
	logic [TAG_W-1:0]  tag_d;
	logic [SET_W-1:0]  set_d;

	always_comb begin
		sb       = (int'(cfg.set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg.set_bits;
		split    = {4'd0, sb} + {1'b0, cfg.block_bits};
		tag_d    = (split >= 7'd64) ? '0 : (address >> split);
		set_mask = ~({ADDR_W{1'b1}} << sb);
		set_full = (address >> cfg.block_bits) & set_mask;
		set_d    = set_full[SET_W-1:0];
	end

	// lookup
	logic [WCNT_W-1:0]   ways_n;
	logic [MAX_WAYS-1:0] way_mask;
	logic [MAX_WAYS-1:0] vrow;
	logic                any_hit;
	logic                any_free;
	logic [WAY_W-1:0]    hit_way;
	logic [WAY_W-1:0]    free_way;
	logic [WAY_W-1:0]    victim;
	logic [WAY_W-1:0]    tgt_way;
	logic [REC_W-1:0]    hit_rec;
	rec_row_t            new_rec;
	tag_row_t            new_tags;
	logic [MAX_WAYS-1:0] new_vrow;
	logic                cmd_ok;
	logic                is_mod;
	logic                evict;

	always_comb begin
		if (cfg.ways_in_use == 3'd0) begin
			ways_n = WCNT_W'(1);
		end else if (int'(cfg.ways_in_use) > MAX_WAYS) begin
			ways_n = WCNT_W'(MAX_WAYS);
		end else begin
			ways_n = WCNT_W'(cfg.ways_in_use);
		end
		vrow     = valid_q[set_q];
		any_hit  = 1'b0;
		any_free = 1'b0;
		hit_way  = '0;
		free_way = '0;
		victim   = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			way_mask[w] = (WCNT_W'(w) < ways_n);
		end
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (!any_hit && way_mask[w] && vrow[w] && rd_tags_s1[w] == tag_q) begin
				any_hit = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!any_free && way_mask[w] && !vrow[w]) begin
				any_free = 1'b1;
				free_way = WAY_W'(w);
			end
		end
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (way_mask[w] && rd_rec_s1[w] > rd_rec_s1[victim]) begin
				victim = WAY_W'(w);
			end
		end
		evict   = !any_hit && !any_free;
		tgt_way = any_hit ? hit_way : (any_free ? free_way : victim);
		hit_rec = rd_rec_s1[hit_way];
		new_tags = rd_tags_s1;
		new_vrow = vrow;
		for (int w = 0; w < MAX_WAYS; w++) begin
			new_rec[w] = rd_rec_s1[w];
			if (WAY_W'(w) == tgt_way) begin
				new_rec[w] = '0;
				if (!any_hit) begin
					new_tags[w] = tag_q;
					new_vrow[w] = 1'b1;
				end
			end else if (way_mask[w] && vrow[w]) begin
				if (any_hit ? (rd_rec_s1[w] < hit_rec) : (rd_rec_s1[w] < REC_MAX)) begin
					new_rec[w] = rd_rec_s1[w] + REC_W'(1);
				end
			end
		end
		cmd_ok = (cmd_q == CMD_LOAD) || (cmd_q == CMD_STORE) || (cmd_q == CMD_MODIFY);
		is_mod = (cmd_q == CMD_MODIFY);
	end

	// memories
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_tags_s1 <= tag_mem[set_d];
			rd_rec_s1  <= rec_mem[set_d];
			cmd_q      <= command;
			tag_q      <= tag_d;
			set_q      <= set_d;
		end
		if (ctl.lookup_en && cmd_ok) begin
			tag_mem[set_q] <= new_tags;
			rec_mem[set_q] <= new_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			hits_q        <= '0;
			misses_q      <= '0;
			evict_q       <= '0;
			done_q        <= 1'b0;
			was_hit_q     <= 1'b0;
			was_evicted_q <= 1'b0;
			second_hit_q  <= 1'b0;
		end else begin
			done_q <= ctl.lookup_en;
			if (ctl.lookup_en) begin
				was_hit_q     <= cmd_ok && any_hit;
				was_evicted_q <= cmd_ok && evict;
				second_hit_q  <= cmd_ok && is_mod;
				if (cmd_ok) begin
					valid_q[set_q] <= new_vrow;
					hits_q   <= sat_add(hits_q, {1'b0, any_hit} + {1'b0, is_mod});
					misses_q <= sat_add(misses_q, {1'b0, !any_hit});
					evict_q  <= sat_add(evict_q, {1'b0, evict});
				end
			end
		end
	end

	assign done            = done_q;
	assign was_hit         = was_hit_q;
	assign was_evicted     = was_evicted_q;
	assign second_hit      = second_hit_q;
	assign hits_total      = hits_q;
	assign misses_total    = misses_q;
	assign evictions_total = evict_q;

endmodule

// ----- sv/set_assoc_cache_lru_model_unit.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_model_unit
// Set-associative cache model with true LRU replacement and saturating
// hit, miss and eviction totals.
//
//   channel   handshake                 beat contents
//   --------  ------------------------  --------------------------------------
//   access    start & !busy             command, address
//   result    done (one cycle strobe)   was_hit, was_evicted, second_hit,
//                                       hits_total, misses_total, evictions_total
//   config    psel & penable & pwrite   paddr, pwdata (prdata on reads)
//
// Each access is a set-row read of the tag/recency memory, then a lookup
// that writes the row back for a valid command; a modify counts its second
// hit in the same lookup. The result shows in the cycle after the lookup,
// when the next access may already be accepted. Valid bits are flops
// cleared by reset, so no clearing pass is needed. Results cannot be stalled.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_model_unit
	import sacl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [ADDR_W-1:0]  address,
	output logic               done,
	output logic               was_hit,
	output logic               was_evicted,
	output logic               second_hit,
	output logic [CNT_W-1:0]   hits_total,
	output logic [CNT_W-1:0]   misses_total,
	output logic [CNT_W-1:0]   evictions_total
);

	cfg_t cfg;
	ctl_t ctl;

	sacl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sacl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl)
	);

	sacl_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.cfg             (cfg),
		.command         (command),
		.address         (address),
		.done            (done),
		.was_hit         (was_hit),
		.was_evicted     (was_evicted),
		.second_hit      (second_hit),
		.hits_total      (hits_total),
		.misses_total    (misses_total),
		.evictions_total (evictions_total)
	);

endmodule

// ----- sv/sacl_checker.sv -----
// ----------------------------------------------------------------------------
// sacl_checker
// Port-level checks on access sequencing and result consistency.
// ----------------------------------------------------------------------------
module sacl_checker
	import sacl_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic             was_hit,
	input logic             was_evicted,
	input logic             second_hit,
	input logic [CNT_W-1:0] hits_total
);

	// an accepted beat is in lookup next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted access did not go busy");

	// busy is followed in the next cycle by a result and by not busy
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("lookup did not produce a result");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(was_hit && was_evicted))
		else $error("hit reported together with eviction");

	a_second_counts: assert property (@(posedge clk) disable iff (!arst_n)
		done && second_hit |-> hits_total != $past(hits_total, 2) || hits_total == COUNT_MAX)
		else $error("modify did not count its second hit");

endmodule

bind set_assoc_cache_lru_model_unit sacl_checker u_sacl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.was_hit     (was_hit),
	.was_evicted (was_evicted),
	.second_hit  (second_hit),
	.hits_total  (hits_total)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for set_assoc_cache_lru_model_unit. Drives load, store,
// modify and unknown-command accesses under a series of cache geometries set
// over APB. An in-bench LRU cache tracks every line and counter and predicts
// each result beat. Traffic is mostly aimed at a few crowded sets so that
// fills, hits and evictions all occur. Each beat is compared field by field.
// ----------------------------------------------------------------------------
module tb;
	import sacl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int NUM_LINES   = NUM_SETS * MAX_WAYS;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 147;

	typedef struct {
		logic             hit;
		logic             evicted;
		logic             second;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] misses;
		logic [CNT_W-1:0] evicts;
	} outcome_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         command = CMD_LOAD;
	logic [ADDR_W-1:0]  address = '0;
	logic               done;
	logic               was_hit;
	logic               was_evicted;
	logic               second_hit;
	logic [CNT_W-1:0]   hits_total;
	logic [CNT_W-1:0]   misses_total;
	logic [CNT_W-1:0]   evictions_total;

	set_assoc_cache_lru_model_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.address         (address),
		.done            (done),
		.was_hit         (was_hit),
		.was_evicted     (was_evicted),
		.second_hit      (second_hit),
		.hits_total      (hits_total),
		.misses_total    (misses_total),
		.evictions_total (evictions_total)
	);

	always #5 clk = ~clk;

	// cache image
	logic             line_ok  [NUM_LINES];
	logic [TAG_W-1:0] line_tg  [NUM_LINES];
	logic [REC_W-1:0] line_age [NUM_LINES];
	logic [CNT_W-1:0] hit_cnt = '0;
	logic [CNT_W-1:0] miss_cnt = '0;
	logic [CNT_W-1:0] evict_cnt = '0;
	logic [2:0]       geo_set_bits = 3'd0;
	logic [5:0]       geo_block_bits = 6'd0;
	logic [2:0]       geo_ways = 3'd1;

	outcome_t outcome_q[$];
	int       mismatch_cnt = 0;
	int       access_cnt = 0;
	int       beat_cnt = 0;
	int       geometry_cnt = 0;
	int       burst_left = 0;
	int       cycle_cnt = 0;

	initial begin
		for (int i = 0; i < NUM_LINES; i++) begin
			line_ok[i]  = 1'b0;
			line_tg[i]  = '0;
			line_age[i] = '0;
		end
	end

	function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic void grow_older(int unsigned idx);
		if (line_age[idx] < REC_MAX)
			line_age[idx] = line_age[idx] + 1'b1;
	endfunction

	function automatic int unsigned used_set_bits();
		return (int'(geo_set_bits) > MAX_SET_BITS) ? MAX_SET_BITS : int'(geo_set_bits);
	endfunction

	function automatic int unsigned used_ways();
		if (geo_ways == 3'd0)
			return 1;
		return (int'(geo_ways) > MAX_WAYS) ? MAX_WAYS : int'(geo_ways);
	endfunction

	function automatic logic probe_set(int unsigned base, int unsigned ways,
			logic [TAG_W-1:0] tag, output logic evicted);
		int unsigned      hit_way;
		int unsigned      fill_way;
		int unsigned      victim;
		logic [REC_W-1:0] r;
		evicted  = 1'b0;
		hit_way  = ways;
		fill_way = ways;
		victim   = 0;
		for (int unsigned w = 0; w < ways; w++) begin
			if (line_ok[base + w] && line_tg[base + w] == tag) begin
				hit_way = w;
				break;
			end
		end
		if (hit_way < ways) begin
			r = line_age[base + hit_way];
			for (int unsigned w = 0; w < ways; w++)
				if (w != hit_way && line_ok[base + w] && line_age[base + w] < r)
					grow_older(base + w);
			line_age[base + hit_way] = '0;
			hit_cnt = bump(hit_cnt);
			return 1'b1;
		end
		miss_cnt = bump(miss_cnt);
		for (int unsigned w = 0; w < ways; w++) begin
			if (!line_ok[base + w]) begin
				fill_way = w;
				break;
			end
		end
		if (fill_way == ways) begin
			for (int unsigned w = 1; w < ways; w++)
				if (line_age[base + w] > line_age[base + victim])
					victim = w;
			fill_way  = victim;
			evicted   = 1'b1;
			evict_cnt = bump(evict_cnt);
		end
		for (int unsigned w = 0; w < ways; w++)
			if (w != fill_way && line_ok[base + w])
				grow_older(base + w);
		line_ok[base + fill_way]  = 1'b1;
		line_tg[base + fill_way]  = tag;
		line_age[base + fill_way] = '0;
		return 1'b0;
	endfunction

	function automatic outcome_t predict_access(logic [1:0] cmd, logic [ADDR_W-1:0] addr);
		outcome_t         o;
		int unsigned      sb;
		int unsigned      bb;
		int unsigned      ways;
		logic [TAG_W-1:0] tag;
		logic [ADDR_W-1:0] set_idx;
		logic             ev;
		logic             ignored;
		sb   = used_set_bits();
		bb   = 32'(geo_block_bits);
		ways = used_ways();
		tag  = (sb + bb >= 64) ? '0 : (addr >> (sb + bb));
		set_idx = (addr >> bb) & ((64'd1 << sb) - 1);
		o.hit     = 1'b0;
		o.evicted = 1'b0;
		o.second  = 1'b0;
		if (cmd == CMD_LOAD || cmd == CMD_STORE || cmd == CMD_MODIFY) begin
			o.hit     = probe_set(32'(set_idx) * MAX_WAYS, ways, tag, ev);
			o.evicted = ev;
			if (cmd == CMD_MODIFY)
				o.second = probe_set(32'(set_idx) * MAX_WAYS, ways, tag, ignored);
		end
		o.hits   = hit_cnt;
		o.misses = miss_cnt;
		o.evicts = evict_cnt;
		return o;
	endfunction

	// address whose tag, set and offset land where the current geometry puts them
	function automatic logic [ADDR_W-1:0] place(logic [TAG_W-1:0] tag, int unsigned set_idx,
			logic [ADDR_W-1:0] offset);
		int unsigned       sb;
		int unsigned       bb;
		logic [ADDR_W-1:0] a;
		sb = used_set_bits();
		bb = 32'(geo_block_bits);
		a  = offset & ((64'd1 << bb) - 1);
		a  = a | ((ADDR_W'(set_idx) & ((64'd1 << sb) - 1)) << bb);
		if (sb + bb < 64)
			a = a | (tag << (sb + bb));
		return a;
	endfunction

	task automatic send_access(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr);
		start   <= 1'b1;
		command <= cmd;
		address <= addr;
		do @(posedge clk); while (busy);
		outcome_q.push_back(predict_access(cmd, addr));
		access_cnt++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] mask;
		drain_results();
		mask = (idx == REG_BLOCK_BITS) ? 32'h3f : 32'h7;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_SET_BITS:    geo_set_bits   = value[2:0];
			REG_BLOCK_BITS:  geo_block_bits = value[5:0];
			default:         geo_ways       = value[2:0];
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) != (value & mask))
			$error("register %0d readback: expected %0h, got %0h", idx, value & mask,
				prdata & mask);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_geometry(input int sb, input int bb, input int ways);
		write_register(REG_SET_BITS, 32'(sb));
		write_register(REG_BLOCK_BITS, 32'(bb));
		write_register(REG_WAYS_IN_USE, 32'(ways));
		geometry_cnt++;
	endtask

	task automatic test_default_geometry();
		geometry_cnt++;
		send_access(CMD_LOAD, 64'h0);
		send_access(CMD_LOAD, 64'h0);
		send_access(CMD_STORE, '1);
		send_access(CMD_MODIFY, '1);
		send_access(CMD_LOAD, 64'h0);
		send_access(CMD_UNKNOWN, '1);
		send_access(CMD_MODIFY, 64'h5555_5555_5555_5555);
		send_access(CMD_STORE, 64'haaaa_aaaa_aaaa_aaaa);
	endtask

	task automatic test_lru_replacement();
		set_geometry(2, 4, 4);
		send_access(CMD_LOAD, place(64'd10, 1, 64'h3));
		send_access(CMD_LOAD, place(64'd11, 1, 64'h0));
		send_access(CMD_STORE, place(64'd12, 1, 64'hf));
		send_access(CMD_LOAD, place(64'd13, 1, 64'h7));
		send_access(CMD_LOAD, place(64'd10, 1, 64'h1));
		send_access(CMD_STORE, place(64'd14, 1, 64'h2));
		send_access(CMD_MODIFY, place(64'd11, 1, 64'h4));
		send_access(CMD_LOAD, place(64'd10, 1, 64'h5));
		send_access(CMD_LOAD, place(64'd12, 1, 64'h6));
		send_access(CMD_LOAD, place(64'd14, 2, 64'h8));
		send_access(CMD_MODIFY, place(64'd10, 1, 64'h9));
		send_access(CMD_UNKNOWN, place(64'd10, 1, 64'ha));
	endtask

	task automatic test_wide_split();
		set_geometry(7, 63, 4);
		send_access(CMD_LOAD, 64'h0);
		send_access(CMD_LOAD, 64'h8000_0000_0000_0000);
		send_access(CMD_STORE, '1);
		send_access(CMD_MODIFY, 64'h1);
		set_geometry(6, 57, 0);
		send_access(CMD_LOAD, '1);
	endtask

	task automatic test_random_traffic();
		int               fixed_sb [5] = '{7, 6, 3, 2, 0};
		int               fixed_bb [5] = '{63, 57, 6, 4, 0};
		int               fixed_wy [5] = '{7, 4, 0, 4, 4};
		logic [TAG_W-1:0] tag_base;
		logic [1:0]       cmd;
		logic [ADDR_W-1:0] addr;
		int               r;
		bit               idle_on;
		for (int ph = 0; ph < 9; ph++) begin
			if (ph < 5)
				set_geometry(fixed_sb[ph], fixed_bb[ph], fixed_wy[ph]);
			else
				set_geometry($urandom_range(0, 7),
					($urandom_range(0, 3) == 0) ? $urandom_range(40, 63) : $urandom_range(0, 8),
					$urandom_range(0, 7));
			tag_base = {$urandom, $urandom};
			idle_on  = (ph % 3 != 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 3)       cmd = CMD_UNKNOWN;
				else if (r < 35) cmd = CMD_LOAD;
				else if (r < 65) cmd = CMD_STORE;
				else             cmd = CMD_MODIFY;
				if ($urandom_range(0, 9) == 0)
					addr = {$urandom, $urandom};
				else
					addr = place(tag_base ^ TAG_W'($urandom_range(0, used_ways() + 1)),
						$urandom_range(0, 3), {$urandom, $urandom});
				send_access(cmd, addr);
				if (ph == 0 && i == PHASE_ITEMS / 2) begin
					drain_results();
				end else if (idle_on) begin
					if (burst_left == 0) begin
						start <= 1'b0;
						repeat ($urandom_range(1, 6)) @(posedge clk);
						burst_left = $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end
			end
		end
	endtask

	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && done) begin
			beat_cnt++;
			if (outcome_q.size() == 0) begin
				$error("result beat with no access pending");
				mismatch_cnt++;
			end else begin
				want = outcome_q.pop_front();
				if (was_hit !== want.hit) begin
					$error("was_hit: expected %0d, got %0d", want.hit, was_hit);
					mismatch_cnt++;
				end
				if (was_evicted !== want.evicted) begin
					$error("was_evicted: expected %0d, got %0d", want.evicted, was_evicted);
					mismatch_cnt++;
				end
				if (second_hit !== want.second) begin
					$error("second_hit: expected %0d, got %0d", want.second, second_hit);
					mismatch_cnt++;
				end
				if (hits_total !== want.hits) begin
					$error("hits_total: expected %0d, got %0d", want.hits, hits_total);
					mismatch_cnt++;
				end
				if (misses_total !== want.misses) begin
					$error("misses_total: expected %0d, got %0d", want.misses, misses_total);
					mismatch_cnt++;
				end
				if (evictions_total !== want.evicts) begin
					$error("evictions_total: expected %0d, got %0d", want.evicts,
						evictions_total);
					mismatch_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				outcome_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_geometry();
		test_lru_replacement();
		test_wide_split();
		test_random_traffic();
		drain_results();
		repeat (8) @(posedge clk);
		if (outcome_q.size() != 0) begin
			$error("%0d expected results never arrived", outcome_q.size());
			mismatch_cnt++;
		end
		$display("%0d accesses over %0d cache geometries, %0d result beats checked",
			access_cnt, geometry_cnt, beat_cnt);
		$display("cache totals: %0d hits, %0d misses, %0d evictions", hit_cnt, miss_cnt,
			evict_cnt);
		if (mismatch_cnt == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/sacl_pkg.sv
sv/sacl_regs.sv
sv/sacl_ctrl.sv
sv/sacl_dpath.sv
sv/set_assoc_cache_lru_model_unit.sv
sv/sacl_checker.sv
bench/tb.sv
